// File: rtl/core/rope_pkg.sv
// Shared types, constants and fp32 helper functions for the rotary position
// embedding block. No dependencies; every other file in rtl/core uses it.
package rope_pkg;

	// Field widths fixed by the request and result formats
	localparam int POS_W   = 11;
	localparam int PAIR_W  = 6;
	localparam int PPH_W   = 7;
	localparam int BF_W    = 16;
	localparam int F32_W   = 32;
	localparam int STAT_W  = 2;
	localparam int TBL_W   = 2 * F32_W;

	// Defaults for the top-level parameters
	localparam int MAX_POSITIONS_DEF = 2048;
	localparam int MAX_PAIRS_DEF     = 64;
	localparam int TBL_DEPTH_DEF     = MAX_POSITIONS_DEF * MAX_PAIRS_DEF;
	localparam logic [PPH_W-1:0] PPH_RESET = 7'd64;

	// Request type codes
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_ROTATE = 1'b1;

	// Internal arithmetic widths
	localparam int EXP_W = 12;
	localparam int FLD_W = 82;
	localparam int SUM_W = FLD_W + 1;

	localparam logic signed [EXP_W-1:0] E_LSB_F32 = 12'sd150;
	localparam logic signed [EXP_W-1:0] X_OFS     = 12'sd16;
	localparam logic signed [EXP_W-1:0] MAN_TOP   = 12'sd23;
	localparam logic signed [EXP_W-1:0] PROD_TOP  = 12'sd31;
	localparam logic signed [EXP_W-1:0] E_MIN     = -12'sd126;
	localparam logic signed [EXP_W-1:0] E_MAX     = 12'sd127;
	localparam logic signed [EXP_W-1:0] E_BIAS_M1 = 12'sd126;
	localparam logic signed [EXP_W-1:0] SUB_LIM   = 12'sd33;
	localparam logic signed [EXP_W-1:0] FLD_LIM   = 12'sd82;

	localparam logic [F32_W-1:0] F32_QNAN = 32'h7FC0_0000;
	localparam logic [30:0]      F32_INF  = 31'h7F80_0000;
	localparam logic [BF_W-1:0]  BF_QNAN  = 16'h7FC0;
	localparam logic [14:0]      BF_INF   = 15'h7F80;

	typedef enum logic [STAT_W-1:0] {
		ST_ROTATED = 2'd0,
		ST_LOADED  = 2'd1,
		ST_RANGE   = 2'd2
	} rope_status_t;

	typedef struct packed {
		rope_status_t status;
		logic         last;
	} rope_ctrl_t;

	// Unpacked fp32: significand with hidden bit and exponent of its lsb
	typedef struct packed {
		logic                    sgn;
		logic                    nan;
		logic                    inf;
		logic                    zero;
		logic [23:0]             man;
		logic signed [EXP_W-1:0] lsb;
	} f32_t;

	typedef struct packed {
		logic sgn;
		logic nan;
		logic inf;
		logic zero;
	} cls_t;

	// Product term: significand and exponent (of lsb, or of msb once normalised)
	typedef struct packed {
		cls_t                    cls;
		logic [31:0]             m;
		logic signed [EXP_W-1:0] e;
	} term_t;

	// Special outcome of the final add
	typedef struct packed {
		logic nan;
		logic inf;
		logic inf_sgn;
		logic both_zero;
		logic zero_sgn;
	} spec_t;

	function automatic f32_t dec_f32(input logic [F32_W-1:0] b);
		f32_t       r;
		logic [7:0] ee;
		ee = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		r.sgn  = b[31];
		r.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		r.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		r.zero = (b[30:23] == 8'd0) && (b[22:0] == 23'd0);
		r.man  = {b[30:23] != 8'd0, b[22:0]};
		r.lsb  = signed'(EXP_W'(ee)) - E_LSB_F32;
		return r;
	endfunction

	// Exact product of a bf16 value and an fp32 value
	function automatic term_t mul_term(input f32_t x, input f32_t t, input logic neg);
		term_t r;
		r.cls.sgn  = x.sgn ^ t.sgn ^ neg;
		r.cls.nan  = x.nan | t.nan | (x.inf & t.zero) | (x.zero & t.inf);
		r.cls.inf  = (x.inf | t.inf) & ~r.cls.nan;
		r.cls.zero = (x.zero | t.zero) & ~r.cls.nan;
		r.m        = 32'(x.man[23:16]) * 32'(t.man);
		r.e        = signed'(x.lsb) + X_OFS + signed'(t.lsb);
		return r;
	endfunction

	function automatic logic [5:0] lzc32(input logic [31:0] v);
		logic [5:0] c;
		c = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) c = 6'(31 - i);
		end
		return c;
	endfunction

	function automatic logic [6:0] lzc82(input logic [FLD_W-1:0] v);
		logic [6:0] c;
		c = 7'(FLD_W);
		for (int i = 0; i < FLD_W; i++) begin
			if (v[i]) c = 7'(FLD_W - 1 - i);
		end
		return c;
	endfunction

	// Right shift with the shifted-out bits folded into the lsb
	function automatic logic [FLD_W-1:0] shr_stk(input logic [FLD_W-1:0] v,
			input logic signed [EXP_W-1:0] d);
		logic [2*FLD_W-1:0] w;
		logic [6:0]         s;
		s = (d > FLD_LIM) ? 7'(FLD_W) : 7'(d);
		w = {v, {FLD_W{1'b0}}} >> s;
		return w[2*FLD_W-1:FLD_W] | {{(FLD_W-1){1'b0}}, |w[FLD_W-1:0]};
	endfunction

	// Round a normalised 32-bit significand (msb weight 2^t) plus sticky to
	// fp32, nearest even, with gradual underflow and overflow to infinity
	function automatic logic [30:0] round_f32(input logic [31:0] n, input logic stk,
			input logic signed [EXP_W-1:0] t);
		logic [64:0]             w;
		logic signed [EXP_W-1:0] dd;
		logic [5:0]              d;
		logic                    g;
		logic                    st;
		logic [24:0]             m25;
		logic [30:0]             r;
		dd = E_MIN - t;
		if (t < E_MIN) d = (dd > SUB_LIM) ? 6'd33 : 6'(dd);
		else d = 6'd0;
		w   = {n, 32'd0, stk} >> d;
		g   = w[40];
		st  = |w[39:0];
		m25 = {1'b0, w[64:41]} + 25'(g & (st | w[41]));
		if (t > E_MAX) r = F32_INF;
		else if (t < E_MIN) r = 31'(m25);
		else r = {8'(t + E_BIAS_M1), 23'd0} + 31'(m25);
		return r;
	endfunction

endpackage

// File: rtl/core/rope_req_if.sv
// Request channel of the rotary embedding block: valid/ready plus one
// load or rotate request. Depends on rope_pkg.
interface rope_req_if;
	import rope_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [POS_W-1:0]  position;
	logic [PAIR_W-1:0] pair_index;
	logic [BF_W-1:0]   x1_bits;
	logic [BF_W-1:0]   x2_bits;
	logic [F32_W-1:0]  cos_bits;
	logic [F32_W-1:0]  sin_bits;
	logic              last_in;

	modport source (output valid, req_type, position, pair_index, x1_bits, x2_bits,
		cos_bits, sin_bits, last_in, input ready);
	modport sink (input valid, req_type, position, pair_index, x1_bits, x2_bits,
		cos_bits, sin_bits, last_in, output ready);
endinterface

// File: rtl/core/rope_rsp_if.sv
// Result channel of the rotary embedding block: valid/ready plus the two
// bf16 outputs, status and last flag. Depends on rope_pkg.
interface rope_rsp_if;
	import rope_pkg::*;
	logic              valid;
	logic              ready;
	logic [BF_W-1:0]   out1_bits;
	logic [BF_W-1:0]   out2_bits;
	logic [STAT_W-1:0] status;
	logic              last_out;

	modport source (output valid, out1_bits, out2_bits, status, last_out, input ready);
	modport sink (input valid, out1_bits, out2_bits, status, last_out, output ready);
endinterface

// File: rtl/core/rope_cfg_if.sv
// Configuration write channel: valid/ready and the pairs-per-head value.
// Depends on rope_pkg.
interface rope_cfg_if;
	import rope_pkg::*;
	logic             valid;
	logic             ready;
	logic [PPH_W-1:0] pairs_per_head;

	modport source (output valid, pairs_per_head, input ready);
	modport sink (input valid, pairs_per_head, output ready);
endinterface

// File: rtl/core/rope_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing but rope_pkg for default sizes.
module rope_ram #(
	parameter int WIDTH = rope_pkg::TBL_W,
	parameter int DEPTH = rope_pkg::TBL_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/rope_lane.sv
// One rotation lane: res = bf16_trunc(fma(x1, ta, +/-round32(x2 * tb))).
// Eight register stages under a common enable. Depends on rope_pkg.
module rope_lane (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rope_pkg::BF_W-1:0]  x1,
	input  logic [rope_pkg::BF_W-1:0]  x2,
	input  logic [rope_pkg::F32_W-1:0] ta,
	input  logic [rope_pkg::F32_W-1:0] tb,
	input  logic                      neg,
	output logic [rope_pkg::BF_W-1:0]  res
);
	import rope_pkg::*;

	term_t pa_d, pb_d, pa_s3, pb_s3;
	term_t na_d, nb_d, na_s4, nb_s4;
	logic [F32_W-1:0] q_d, q_s5;
	term_t na_s5;
	logic [FLD_W-1:0] fa_d, fq_d, fa_s6, fq_s6;
	logic sa_s6, sq_s6;
	logic signed [EXP_W-1:0] t_d, t_s6, t_s7, t_s8, tr_d, tr_s9;
	spec_t sp_d, sp_s6, sp_s7, sp_s8, sp_s9;
	logic [SUM_W-1:0] sum_d, sum_s7;
	logic sg_s7, sg_s8, sg_s9, sg_d;
	logic [FLD_W-1:0] mag_d, mag_s8, sh_d;
	logic [6:0] lz82;
	logic [31:0] n_s9;
	logic stk_s9, zero_s9;
	logic [30:0] rnd_d;
	logic [BF_W-1:0] res_d;
	f32_t dq;
	logic signed [EXP_W-1:0] tq;
	logic [5:0] lza, lzb;

	// Widen, decode and form the two exact products
	always_comb begin
		pa_d = mul_term(dec_f32({x1, 16'h0000}), dec_f32(ta), 1'b0);
		pb_d = mul_term(dec_f32({x2, 16'h0000}), dec_f32(tb), neg);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s3 <= pa_d;
			pb_s3 <= pb_d;
		end
	end

	// Normalise both products; exponent now refers to the msb
	always_comb begin
		lza = lzc32(pa_s3.m);
		lzb = lzc32(pb_s3.m);
		na_d = pa_s3;
		nb_d = pb_s3;
		na_d.m = pa_s3.m << lza;
		nb_d.m = pb_s3.m << lzb;
		na_d.e = signed'(pa_s3.e) + PROD_TOP - signed'(EXP_W'(lza));
		nb_d.e = signed'(pb_s3.e) + PROD_TOP - signed'(EXP_W'(lzb));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s4 <= na_d;
			nb_s4 <= nb_d;
		end
	end

	// Round the x2 product to fp32
	always_comb begin
		if (nb_s4.cls.nan) q_d = F32_QNAN;
		else if (nb_s4.cls.inf) q_d = {nb_s4.cls.sgn, F32_INF};
		else if (nb_s4.cls.zero) q_d = {nb_s4.cls.sgn, 31'd0};
		else q_d = {nb_s4.cls.sgn, round_f32(nb_s4.m, 1'b0, signed'(nb_s4.e))};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s5  <= q_d;
			na_s5 <= na_s4;
		end
	end

	// Classify the sum and align both terms to the larger exponent
	always_comb begin
		dq = dec_f32(q_s5);
		tq = signed'(dq.lsb) + MAN_TOP;
		sp_d.nan = na_s5.cls.nan | dq.nan |
			(na_s5.cls.inf & dq.inf & (na_s5.cls.sgn != dq.sgn));
		sp_d.inf = ~sp_d.nan & (na_s5.cls.inf | dq.inf);
		sp_d.inf_sgn = na_s5.cls.inf ? na_s5.cls.sgn : dq.sgn;
		sp_d.both_zero = na_s5.cls.zero & dq.zero;
		sp_d.zero_sgn = na_s5.cls.sgn & dq.sgn;
		if (na_s5.cls.zero) t_d = tq;
		else if (dq.zero) t_d = signed'(na_s5.e);
		else t_d = (signed'(na_s5.e) > tq) ? signed'(na_s5.e) : tq;
		fa_d = shr_stk({1'b0, na_s5.cls.zero ? 32'd0 : na_s5.m, 49'd0},
			t_d - signed'(na_s5.e));
		fq_d = shr_stk({1'b0, dq.man, 57'd0}, t_d - tq);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fa_s6 <= fa_d;
			fq_s6 <= fq_d;
			sa_s6 <= na_s5.cls.sgn;
			sq_s6 <= dq.sgn;
			t_s6  <= t_d;
			sp_s6 <= sp_d;
		end
	end

	// Add or subtract the aligned terms
	always_comb begin
		if (sa_s6 == sq_s6) sum_d = {1'b0, fa_s6} + {1'b0, fq_s6};
		else sum_d = {1'b0, fa_s6} - {1'b0, fq_s6};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s7 <= sum_d;
			sg_s7  <= sa_s6;
			t_s7   <= t_s6;
			sp_s7  <= sp_s6;
		end
	end

	// Take the magnitude of a negative difference
	always_comb begin
		if (sum_s7[SUM_W-1]) begin
			mag_d = FLD_W'(-sum_s7);
			sg_d  = ~sg_s7;
		end else begin
			mag_d = sum_s7[FLD_W-1:0];
			sg_d  = sg_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s8 <= mag_d;
			sg_s8  <= sg_d;
			t_s8   <= t_s7;
			sp_s8  <= sp_s7;
		end
	end

	// Normalise the sum
	always_comb begin
		lz82 = lzc82(mag_s8);
		sh_d = mag_s8 << lz82;
		tr_d = t_s8 + 12'sd1 - signed'(EXP_W'(lz82));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s9    <= sh_d[FLD_W-1:FLD_W-32];
			stk_s9  <= |sh_d[FLD_W-33:0];
			zero_s9 <= (mag_s8 == '0);
			tr_s9   <= tr_d;
			sg_s9   <= sg_s8;
			sp_s9   <= sp_s8;
		end
	end

	// Round once to fp32, then drop the low half
	always_comb begin
		rnd_d = round_f32(n_s9, stk_s9, tr_s9);
		if (sp_s9.nan) res_d = BF_QNAN;
		else if (sp_s9.inf) res_d = {sp_s9.inf_sgn, BF_INF};
		else if (zero_s9) res_d = {sp_s9.both_zero & sp_s9.zero_sgn, 15'd0};
		else res_d = {sg_s9, rnd_d[30:16]};
	end

	always_ff @(posedge clk) begin
		if (en) res <= res_d;
	end
endmodule

// File: rtl/core/rope_bf16_rotate.sv
// Rotary position embedding on bf16 pairs with an on-chip fp32 cos/sin table.
// A request passes through ten register stages: input, table read and
// eight arithmetic stages.
// Throughput: one request per cycle; the pipeline stalls only on result ready.
// Reset clears the stage valid bits and sets pairs_per_head to 64; the table
// is not cleared and must be loaded before rotation requests read it.
module rope_bf16_rotate #(
	parameter int MAX_POSITIONS = rope_pkg::MAX_POSITIONS_DEF,
	parameter int MAX_PAIRS     = rope_pkg::MAX_PAIRS_DEF
) (
	input logic clk,
	input logic arst_n,
	rope_req_if.sink   req,
	rope_cfg_if.sink   cfg,
	rope_rsp_if.source rsp
);
	import rope_pkg::*;

	localparam int DEPTH = MAX_POSITIONS * MAX_PAIRS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MOD_W = POS_W + 18;
	localparam int NSTG  = 10;

	logic adv;
	logic [NSTG:1] v_s;
	logic [PPH_W-1:0] pph_q;

	logic [MOD_W-1:0] rem;
	logic in_ok;
	rope_ctrl_t ctrl_d;

	logic req_type_s1, ok_s1;
	logic [POS_W-1:0] row_s1;
	logic [PAIR_W-1:0] pair_s1;
	logic [BF_W-1:0] x1_s1, x2_s1, x1_s2, x2_s2;
	logic [F32_W-1:0] cos_s1, sin_s1;
	rope_ctrl_t ctrl_s [1:NSTG];
	logic [AW-1:0] addr_s1;
	logic [TBL_W-1:0] tbl_s2;
	logic [BF_W-1:0] res1, res2;
	logic tbl_we;

	// Advance the whole pipeline unless the result is held
	assign adv       = ~v_s[NSTG] | rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pph_q <= PPH_RESET;
		end else if (cfg.valid) begin
			pph_q <= cfg.pairs_per_head;
		end
	end

	// Reduce the position to a table row and check the pair index
	always_comb begin
		rem = MOD_W'(req.position);
		for (int k = POS_W - 1; k >= 0; k--) begin
			if (rem >= (MOD_W'(MAX_POSITIONS) << k)) rem = rem - (MOD_W'(MAX_POSITIONS) << k);
		end
		in_ok = ({1'b0, req.pair_index} < pph_q) && (32'(req.pair_index) < MAX_PAIRS);
		if (!in_ok) ctrl_d.status = ST_RANGE;
		else if (req.req_type == REQ_LOAD) ctrl_d.status = ST_LOADED;
		else ctrl_d.status = ST_ROTATED;
		ctrl_d.last = (req.req_type == REQ_ROTATE) & req.last_in;
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NSTG-1:1], req.valid};
		end
	end

	// Stage 1: hold the accepted request
	always_ff @(posedge clk) begin
		if (adv) begin
			req_type_s1 <= req.req_type;
			ok_s1       <= in_ok;
			row_s1      <= rem[POS_W-1:0];
			pair_s1     <= req.pair_index;
			x1_s1       <= req.x1_bits;
			x2_s1       <= req.x2_bits;
			cos_s1      <= req.cos_bits;
			sin_s1      <= req.sin_bits;
			ctrl_s[1]   <= ctrl_d;
		end
	end

	assign addr_s1 = AW'(32'(row_s1) * MAX_PAIRS + 32'(pair_s1));
	assign tbl_we  = adv & v_s[1] & ok_s1 & (req_type_s1 == REQ_LOAD);

	// Table read and write at stage 1; read data lands in stage 2
	rope_ram #(
		.WIDTH (TBL_W),
		.DEPTH (DEPTH)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (addr_s1),
		.wdata ({cos_s1, sin_s1}),
		.re    (adv),
		.raddr (addr_s1),
		.rdata (tbl_s2)
	);

	// Advance operands and control alongside the lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s2 <= x1_s1;
			x2_s2 <= x2_s1;
			for (int i = 2; i <= NSTG; i++) begin
				ctrl_s[i] <= ctrl_s[i-1];
			end
		end
	end

	// out1 = fma(x1, cos, -round(x2 * sin))
	rope_lane u_lane1 (
		.clk (clk),
		.en  (adv),
		.x1  (x1_s2),
		.x2  (x2_s2),
		.ta  (tbl_s2[TBL_W-1:F32_W]),
		.tb  (tbl_s2[F32_W-1:0]),
		.neg (1'b1),
		.res (res1)
	);

	// out2 = fma(x1, sin, round(x2 * cos))
	rope_lane u_lane2 (
		.clk (clk),
		.en  (adv),
		.x1  (x1_s2),
		.x2  (x2_s2),
		.ta  (tbl_s2[F32_W-1:0]),
		.tb  (tbl_s2[TBL_W-1:F32_W]),
		.neg (1'b0),
		.res (res2)
	);

	// Drive the result; only a rotated pair carries data
	assign rsp.valid     = v_s[NSTG];
	assign rsp.out1_bits = (ctrl_s[NSTG].status == ST_ROTATED) ? res1 : '0;
	assign rsp.out2_bits = (ctrl_s[NSTG].status == ST_ROTATED) ? res2 : '0;
	assign rsp.status    = ctrl_s[NSTG].status;
	assign rsp.last_out  = ctrl_s[NSTG].last;
endmodule
